/* rtl/psp_pkg.sv */
// ----------------------------------------------------------------------------
// psp_pkg
// Shared widths, codes and reset values of the pulse speed PID/PWM regulator.
// ----------------------------------------------------------------------------
package psp_pkg;

  // Revolution counter width and number of fraction bits in the gains.
  localparam int COUNT_W = 8;
  localparam int FRAC_W  = 16;

  // Fixed field widths.
  localparam int KIND_W   = 2;
  localparam int RAW_W    = 12;
  localparam int GAIN_W   = 20;
  localparam int DRIVE_W  = 10;
  localparam int PCT_W    = 7;
  localparam int RPM_W    = 12;
  localparam int SPEED_W  = 17;
  localparam int REG_W    = 3;
  localparam int CFG_D_W  = 20;
  localparam int ACC_W    = 48;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_PULSE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SETPOINT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;

  // Configuration register indexes.
  localparam logic [REG_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [REG_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [REG_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [REG_W-1:0] REG_DRIVE_HIGH = 3'd3;
  localparam logic [REG_W-1:0] REG_DRIVE_LOW  = 3'd4;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 20'd10767;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 20'd66;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 20'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_HIGH_RST = 10'd1000;
  localparam logic [DRIVE_W-1:0] DRIVE_LOW_RST  = 10'd0;

  // Scaling constants.
  localparam int FB_PER_PULSE  = 2400;
  localparam int RPM_PER_PULSE = 300;
  localparam int SETPOINT_MUL  = 10;
  localparam int SETPOINT_MAX  = 3000;
  localparam int DUTY_FULL     = 1000;
  localparam int SPEED_MAX     = 131071;

  // Derived arithmetic widths.
  localparam int FB_W   = COUNT_W + 12;                     // count * 2400
  localparam int ERR_W  = FB_W + 1;                         // signed error
  localparam int DERR_W = ERR_W + 1;                        // error difference
  localparam int PP_W   = GAIN_W + 1 + ERR_W;               // gain * error
  localparam int PD_W   = GAIN_W + 1 + DERR_W;              // gain * difference
  localparam int PPD_W  = PD_W + 1;                         // P + D terms
  localparam int IW     = ((ACC_W > PP_W) ? ACC_W : PP_W) + 1;
  localparam int SUM_W  = ((ACC_W > PPD_W) ? ACC_W : PPD_W) + 1;
  localparam int Q_W    = SUM_W - FRAC_W;                   // integer part
  localparam int SPW    = COUNT_W + 9;                      // count * 300
  localparam int SPX_W  = (SPW > SPEED_W) ? SPW : SPEED_W;

endpackage

/* rtl/psp_if.sv */
// ----------------------------------------------------------------------------
// psp_if
// Valid/ready channels of the regulator: input items, results, register writes.
// ----------------------------------------------------------------------------
interface psp_in_if
  import psp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [RAW_W-1:0]  setpoint_raw;

  modport source (output valid, output kind, output setpoint_raw, input ready);
  modport sink   (input valid, input kind, input setpoint_raw, output ready);
endinterface

interface psp_out_if
  import psp_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               is_control;
  logic [DRIVE_W-1:0] duty_permille;
  logic [PCT_W-1:0]   duty_percent;
  logic [RPM_W-1:0]   setpoint_rpm;
  logic [SPEED_W-1:0] speed_rpm;

  modport source (output valid, output is_control, output duty_permille,
                  output duty_percent, output setpoint_rpm, output speed_rpm,
                  input ready);
  modport sink   (input valid, input is_control, input duty_permille,
                  input duty_percent, input setpoint_rpm, input speed_rpm,
                  output ready);
endinterface

interface psp_cfg_if
  import psp_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [REG_W-1:0]   index;
  logic [CFG_D_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/pulse_speed_pid_pwm.sv */
// ----------------------------------------------------------------------------
// pulse_speed_pid_pwm
// Speed regulator: pulse counter, fixed-point PID step and clamped PWM duty.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transaction
//  in_ch     sink       one item: pulse, setpoint update or sample tick
//  out_ch    source     one result: display update or control result
//  cfg_ch    sink       one register write: gains and drive limits
//
//  Cycles: one item is accepted per cycle while the capture stage can load;
//  the capture stage loads at the accepting edge and a result then passes
//  through the multiply, integrate, sum and clamp stages into the output
//  register. Pulse items update the counter and give no result.
//  Reset: rst_n clears the counter, integral, stored error, target and last
//  duty/speed, and loads the register reset values.
//  Stalls: each stage holds while the next one is full and blocked, so empty
//  stages keep absorbing items while a result waits at the output.
//  cfg_ch is always ready; writes are expected only while the block is idle.
//
module pulse_speed_pid_pwm
  import psp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  psp_in_if.sink    in_ch,
  psp_out_if.source out_ch,
  psp_cfg_if.sink   cfg_ch
);

  // --------------------------------------------------------------------------
  // Configuration registers. The port never pushes back.
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]  kp_r, ki_r, kd_r;
  logic [DRIVE_W-1:0] drv_hi_r, drv_lo_r;

  assign cfg_ch.ready = 1'b1;

  // --------------------------------------------------------------------------
  // Regulator state.
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0]      pulse_count_r;
  logic [RPM_W-1:0]        target_r;
  logic signed [ERR_W-1:0] last_err_r;
  logic [SPEED_W-1:0]      last_speed_r;
  logic signed [ACC_W-1:0] integ_r;
  logic [DRIVE_W-1:0]      last_duty_r;
  logic [PCT_W-1:0]        last_pct_r;

  // --------------------------------------------------------------------------
  // Pipeline stage valids and handshake. A stage can load when it is empty
  // or its current item moves on in the same cycle.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic in_fire, in_is_sp, in_is_tick;

  assign rdy_o = !vo_r || out_ch.ready;
  assign rdy4  = !v4_r || rdy_o;
  assign rdy3  = !v3_r || rdy4;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;

  assign in_ch.ready = rdy1;
  assign in_fire     = in_ch.valid && rdy1;
  assign in_is_sp    = (in_ch.kind == KIND_SETPOINT);
  assign in_is_tick  = (in_ch.kind == KIND_TICK);

  // --------------------------------------------------------------------------
  // Capture stage: setpoint scaling, error, error difference and speed are
  // formed from the current state when the item is accepted.
  // --------------------------------------------------------------------------
  logic [15:0]              sp_x10;
  logic [RPM_W-1:0]         tgt_nxt;
  logic [FB_W-1:0]          fb;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [DERR_W-1:0] derr_nxt;
  logic [SPX_W-1:0]         spd_raw;
  logic [SPEED_W-1:0]       spd_nxt;
  logic [COUNT_W-1:0]       count_nxt;

  assign sp_x10  = 16'(in_ch.setpoint_raw) * 16'(SETPOINT_MUL);
  assign tgt_nxt = (sp_x10 > 16'(SETPOINT_MAX)) ? RPM_W'(SETPOINT_MAX)
                                                 : sp_x10[RPM_W-1:0];

  // Feedback is count * 2400, the target is scaled by 8; the difference fits
  // the signed error width, so a modular subtract gives the right value.
  assign fb       = FB_W'(pulse_count_r) * FB_W'(FB_PER_PULSE);
  assign err_nxt  = $signed(ERR_W'({target_r, 3'b000}) - ERR_W'(fb));
  assign derr_nxt = DERR_W'(err_nxt) - DERR_W'(last_err_r);

  assign spd_raw = SPX_W'(pulse_count_r) * SPX_W'(RPM_PER_PULSE);
  assign spd_nxt = (spd_raw > SPX_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX)
                                                 : spd_raw[SPEED_W-1:0];

  assign count_nxt = (pulse_count_r == {COUNT_W{1'b1}}) ? pulse_count_r
                                                        : pulse_count_r + 1'b1;

  logic                     s1_ctl_r;
  logic [RPM_W-1:0]         s1_tgt_r;
  logic [SPEED_W-1:0]       s1_spd_r;
  logic signed [ERR_W-1:0]  s1_err_r;
  logic signed [DERR_W-1:0] s1_derr_r;

  // --------------------------------------------------------------------------
  // Multiply stage: the three gain products run side by side.
  // --------------------------------------------------------------------------
  logic signed [GAIN_W:0]   kp_s, ki_s, kd_s;
  logic signed [PP_W-1:0]   pp_nxt, pi_nxt;
  logic signed [PD_W-1:0]   pd_nxt;

  assign kp_s   = $signed({1'b0, kp_r});
  assign ki_s   = $signed({1'b0, ki_r});
  assign kd_s   = $signed({1'b0, kd_r});
  assign pp_nxt = PP_W'(kp_s) * PP_W'(s1_err_r);
  assign pi_nxt = PP_W'(ki_s) * PP_W'(s1_err_r);
  assign pd_nxt = PD_W'(kd_s) * PD_W'(s1_derr_r);

  logic                     s2_ctl_r;
  logic [RPM_W-1:0]         s2_tgt_r;
  logic [SPEED_W-1:0]       s2_spd_r;
  logic signed [PP_W-1:0]   s2_pp_r, s2_pi_r;
  logic signed [PD_W-1:0]   s2_pd_r;

  // --------------------------------------------------------------------------
  // Integrate stage: the integral accumulates with signed 48-bit saturation.
  // It is written as a tick moves into the next stage, so successive ticks
  // each see the previous tick's integral.
  // --------------------------------------------------------------------------
  logic signed [IW-1:0]     acc_sum;
  logic                     acc_ovf;
  logic signed [ACC_W-1:0]  integ_nxt;
  logic signed [PPD_W-1:0]  ppd_nxt;

  assign acc_sum   = IW'(integ_r) + IW'(s2_pi_r);
  assign acc_ovf   = !((acc_sum[IW-1:ACC_W-1] == '0) || (acc_sum[IW-1:ACC_W-1] == '1));
  assign integ_nxt = !acc_ovf     ? acc_sum[ACC_W-1:0] :
                     acc_sum[IW-1] ? $signed({1'b1, {(ACC_W-1){1'b0}}})
                                   : $signed({1'b0, {(ACC_W-1){1'b1}}});
  assign ppd_nxt   = PPD_W'(s2_pp_r) + PPD_W'(s2_pd_r);

  logic                     s3_ctl_r;
  logic [RPM_W-1:0]         s3_tgt_r;
  logic [SPEED_W-1:0]       s3_spd_r;
  logic signed [ACC_W-1:0]  s3_integ_r;
  logic signed [PPD_W-1:0]  s3_ppd_r;

  // --------------------------------------------------------------------------
  // Sum stage: control sum with FRAC_W fraction bits.
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0]  sum_nxt;

  assign sum_nxt = SUM_W'(s3_integ_r) + SUM_W'(s3_ppd_r);

  logic                     s4_ctl_r;
  logic [RPM_W-1:0]         s4_tgt_r;
  logic [SPEED_W-1:0]       s4_spd_r;
  logic signed [SUM_W-1:0]  s4_sum_r;

  // --------------------------------------------------------------------------
  // Clamp stage: a negative sum takes the low limit; otherwise the integer
  // part is clamped; with crossed limits a part above the high limit takes it,
  // any other the low limit. Duty is 1000 minus drive, saturating at zero for
  // a drive limit above 1000. Percent is x*205 >> 11, exact for x up to 1000.
  // --------------------------------------------------------------------------
  logic [Q_W-1:0]     q;
  logic [DRIVE_W-1:0] drive;
  logic [DRIVE_W-1:0] duty_tick;
  logic [17:0]        pct_prod;
  logic [PCT_W-1:0]   pct_tick;
  logic [DRIVE_W-1:0] duty_nxt;
  logic [PCT_W-1:0]   pct_nxt;

  assign q = s4_sum_r[SUM_W-1:FRAC_W];

  always_comb begin
    if (s4_sum_r[SUM_W-1]) begin
      drive = drv_lo_r;
    end else if (q > Q_W'(drv_hi_r)) begin
      drive = drv_hi_r;
    end else if (q < Q_W'(drv_lo_r)) begin
      drive = drv_lo_r;
    end else begin
      drive = q[DRIVE_W-1:0];
    end
  end

  assign duty_tick = (drive > DRIVE_W'(DUTY_FULL)) ? '0 : DRIVE_W'(DUTY_FULL) - drive;
  assign pct_prod  = 18'(duty_tick) * 18'd205;
  assign pct_tick  = pct_prod[17:11];

  // A display result shows the duty of the latest tick ahead of it.
  assign duty_nxt = s4_ctl_r ? duty_tick : last_duty_r;
  assign pct_nxt  = s4_ctl_r ? pct_tick  : last_pct_r;

  logic               out_ctl_r;
  logic [DRIVE_W-1:0] out_duty_r;
  logic [PCT_W-1:0]   out_pct_r;
  logic [RPM_W-1:0]   out_tgt_r;
  logic [SPEED_W-1:0] out_spd_r;

  assign out_ch.valid         = vo_r;
  assign out_ch.is_control    = out_ctl_r;
  assign out_ch.duty_permille = out_duty_r;
  assign out_ch.duty_percent  = out_pct_r;
  assign out_ch.setpoint_rpm  = out_tgt_r;
  assign out_ch.speed_rpm     = out_spd_r;

  // --------------------------------------------------------------------------
  // Control state, configuration and regulator state.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r          <= PROP_GAIN_RST;
      ki_r          <= INTEG_GAIN_RST;
      kd_r          <= DERIV_GAIN_RST;
      drv_hi_r      <= DRIVE_HIGH_RST;
      drv_lo_r      <= DRIVE_LOW_RST;
      pulse_count_r <= '0;
      target_r      <= '0;
      last_err_r    <= '0;
      last_speed_r  <= '0;
      integ_r       <= '0;
      last_duty_r   <= '0;
      last_pct_r    <= '0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      v4_r          <= 1'b0;
      vo_r          <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_PROP_GAIN:  kp_r     <= cfg_ch.data[GAIN_W-1:0];
          REG_INTEG_GAIN: ki_r     <= cfg_ch.data[GAIN_W-1:0];
          REG_DERIV_GAIN: kd_r     <= cfg_ch.data[GAIN_W-1:0];
          REG_DRIVE_HIGH: drv_hi_r <= cfg_ch.data[DRIVE_W-1:0];
          REG_DRIVE_LOW:  drv_lo_r <= cfg_ch.data[DRIVE_W-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        if (in_ch.kind == KIND_PULSE) begin
          pulse_count_r <= count_nxt;
        end else if (in_is_sp) begin
          target_r <= tgt_nxt;
        end else if (in_is_tick) begin
          pulse_count_r <= '0;
          last_err_r    <= err_nxt;
          last_speed_r  <= spd_nxt;
        end
      end

      if (rdy3 && v2_r && s2_ctl_r) begin
        integ_r <= integ_nxt;
      end

      if (rdy_o && v4_r && s4_ctl_r) begin
        last_duty_r <= duty_tick;
        last_pct_r  <= pct_tick;
      end

      if (rdy1)  v1_r <= in_ch.valid && (in_is_sp || in_is_tick);
      if (rdy2)  v2_r <= v1_r;
      if (rdy3)  v3_r <= v2_r;
      if (rdy4)  v4_r <= v3_r;
      if (rdy_o) vo_r <= v4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage payloads. Each stage loads whenever it is free to move.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_ctl_r  <= in_is_tick;
      s1_tgt_r  <= in_is_sp ? tgt_nxt : target_r;
      s1_spd_r  <= in_is_tick ? spd_nxt : last_speed_r;
      s1_err_r  <= err_nxt;
      s1_derr_r <= derr_nxt;
    end
    if (rdy2) begin
      s2_ctl_r <= s1_ctl_r;
      s2_tgt_r <= s1_tgt_r;
      s2_spd_r <= s1_spd_r;
      s2_pp_r  <= pp_nxt;
      s2_pi_r  <= pi_nxt;
      s2_pd_r  <= pd_nxt;
    end
    if (rdy3) begin
      s3_ctl_r   <= s2_ctl_r;
      s3_tgt_r   <= s2_tgt_r;
      s3_spd_r   <= s2_spd_r;
      s3_integ_r <= integ_nxt;
      s3_ppd_r   <= ppd_nxt;
    end
    if (rdy4) begin
      s4_ctl_r <= s3_ctl_r;
      s4_tgt_r <= s3_tgt_r;
      s4_spd_r <= s3_spd_r;
      s4_sum_r <= sum_nxt;
    end
    if (rdy_o) begin
      out_ctl_r  <= s4_ctl_r;
      out_duty_r <= duty_nxt;
      out_pct_r  <= pct_nxt;
      out_tgt_r  <= s4_tgt_r;
      out_spd_r  <= s4_spd_r;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // A presented result never shows a duty above full scale.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.duty_permille <= DRIVE_W'(DUTY_FULL)))
    else $error("duty above full scale");

  // The percent field is the per mille field divided by ten, truncated.
  a_pct_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      ((14'(out_ch.duty_percent) * 14'd10 <= 14'(out_ch.duty_permille)) &&
       (14'(out_ch.duty_permille) < 14'(out_ch.duty_percent) * 14'd10 + 14'd10)))
    else $error("duty percent does not match duty per mille");

  // An accepted tick leaves the revolution counter cleared.
  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_is_tick) |=> (pulse_count_r == '0))
    else $error("counter not cleared after tick");

  // The integral moves only when a tick leaves the multiply stage.
  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(rdy3 && v2_r && s2_ctl_r) |=> $stable(integ_r))
    else $error("integral changed without a tick");

  // A stored target never exceeds the setpoint limit.
  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.setpoint_rpm <= RPM_W'(SETPOINT_MAX)))
    else $error("setpoint above limit");

endmodule
